/* hw/rtl/crc15_pkg.sv */
// ============================================================================
// crc15_pkg
// Shared constants and types for the CRC-15 byte stream core.
// ============================================================================
package crc15_pkg;

    localparam int REM_W = 15;
    localparam int BYTE_W = 8;

    // Divisor 0xD2D2 with its leading term dropped and the trailing zero kept.
    localparam logic [REM_W-1:0] CRC_POLY = 15'h52D2;

    typedef logic [REM_W-1:0] rem_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // One finished check result as it leaves the core.
    typedef struct packed {
        logic  remainder_zero;
        byte_t check_low;
        byte_t check_high;
    } crc_result_t;

endpackage

/* hw/rtl/crc15_absorb.sv */
// ============================================================================
// crc15_absorb
// Folds one message byte into the CRC-15 remainder, bit 7 first.
// ============================================================================
module crc15_absorb (
    input  crc15_pkg::rem_t  rem_in,
    input  crc15_pkg::byte_t data_byte,
    output crc15_pkg::rem_t  rem_out
);
    import crc15_pkg::*;

    // Eight serial division steps unrolled into one XOR network.
    always_comb
    begin
        rem_t r;
        logic fb;
        r = rem_in;
        for (int b = BYTE_W - 1; b >= 0; b--)
        begin
            fb = r[REM_W-1] ^ data_byte[b];
            r  = {r[REM_W-2:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        rem_out = r;
    end

endmodule

/* hw/rtl/crc15_result_reg.sv */
// ============================================================================
// crc15_result_reg
// Output register that holds one check result until the sink takes it.
// ============================================================================
module crc15_result_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  crc15_pkg::crc_result_t result_in,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output crc15_pkg::crc_result_t result_out
);
    import crc15_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    crc_result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign m_tvalid   = valid_reg;
    assign result_out = data_reg;

endmodule

/* hw/rtl/crc15_byte_stream_core.sv */
// ============================================================================
// crc15_byte_stream_core
// CRC-15 check byte generator for a byte stream, most significant bit first.
// ============================================================================
// The core takes one message byte per word on the slave side, with tlast
// marking the final byte of a message, and keeps a 15-bit remainder that
// starts at zero after reset. Each byte is divided in, bit 7 first, by the
// degree-15 divisor 0xD2D2. When the last byte has been folded in, the
// core sends one word on the master side carrying the two check bytes and
// a flag that is set when the remainder is zero, which is how a receiver
// checks a message that already ends in its check bytes; the remainder
// then clears for the next message. Non-last bytes produce no output word.
// The core accepts a byte every cycle: an input register feeds the eight
// unrolled division steps, which feed the remainder register and an output
// register; a last byte's result word passes the input register, then the
// output register. The only stall is a last byte that finds the output
// register still holding an untaken result; ordinary bytes always flow.
// ============================================================================
module crc15_byte_stream_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [15:0] m_tdata,  // [7:0] check_high, [15:8] check_low
    output logic       m_tuser    // [0] remainder_zero
);
    import crc15_pkg::*;

    // Input register stage.
    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_byte_reg;
    logic  in_last_reg;

    // Running remainder.
    rem_t  rem_reg;
    rem_t  rem_next;
    rem_t  rem_absorbed;

    logic        advance;
    logic        out_stalled;
    crc_result_t result_new;
    crc_result_t result_held;

    // A held word blocks only a last byte, since only that one needs the
    // output register.
    assign out_stalled = m_tvalid && !m_tready;
    assign advance     = in_valid_reg && !(in_last_reg && out_stalled);
    assign s_tready    = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    crc15_absorb u_absorb (
        .rem_in    (rem_reg),
        .data_byte (in_byte_reg),
        .rem_out   (rem_absorbed)
    );

    // The remainder clears once a message's result has been captured.
    always_comb
    begin
        rem_next = rem_reg;
        if (advance)
        begin
            rem_next = in_last_reg ? '0 : rem_absorbed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    assign result_new.check_high     = rem_absorbed[REM_W-1:REM_W-BYTE_W];
    assign result_new.check_low      = {rem_absorbed[REM_W-BYTE_W-1:0], 1'b0};
    assign result_new.remainder_zero = (rem_absorbed == '0);

    crc15_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && in_last_reg),
        .result_in  (result_new),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result_out (result_held)
    );

    assign m_tdata = {result_held.check_low, result_held.check_high};
    assign m_tuser = result_held.remainder_zero;

    // A message end always leaves a cleared remainder behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> rem_reg == '0)
        else $error("remainder not cleared after last byte");

    // A last byte that moves on always presents a result word next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> m_tvalid)
        else $error("result word missing after last byte");

    // The input side stalls only behind a held result and a pending last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && in_last_reg && m_tvalid && !m_tready)
        else $error("input stalled without cause");

    // The zero flag agrees with the check bytes it travels with.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == (m_tdata == 16'h0000))
        else $error("remainder_zero disagrees with check bytes");

endmodule
